>>> rtl/core/cs_pkg.sv
// ---------------------------------------------------------------------------
// cs_pkg: shared types and constants for the complex sine pipeline
// rotation tables, fixed-point constants and the per-stage lane record
// ---------------------------------------------------------------------------
`default_nettype none

package cs_pkg;

	// rotation stage count, range 12 to 30
	localparam int STAGES = 24;
	// hyperbolic pass repeats shifts 4 and 13 for convergence
	localparam int HYP_N  = STAGES + 1 + ((STAGES >= 13) ? 1 : 0);
	localparam int PIPE_N = HYP_N;

	localparam int DATA_W = 32;
	localparam int W      = 34;

	typedef logic signed [W-1:0]      cs_word_t;
	typedef logic signed [DATA_W-1:0] cs_data_t;

	localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;
	localparam logic [31:0] LOG2E_Q30   = 32'h5C551D95;
	localparam logic [63:0] PI_HALF_Q60 = 64'h1921FB54442D1847;
	localparam logic [63:0] LN2_Q60     = 64'h0B17217F7D1CF79B;
	localparam logic [31:0] CIRC_GAIN   = 32'h26DD3B6A;
	localparam logic [31:0] HYP_GAIN    = 32'd1296540104;
	localparam logic [31:0] Y_LIMIT     = 32'h40000000;

	localparam logic [31:0] ATAN_TAB [30] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	// atanh(2^-i) for i = 1..30, entry i-1
	localparam logic [31:0] ATANH_TAB [30] = '{
		32'd589812981, 32'd274247418, 32'd134923406, 32'd67196450, 32'd33565361,
		32'd16778581, 32'd8388778, 32'd4194325, 32'd2097154, 32'd1048576,
		32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024,
		32'd512, 32'd256, 32'd128, 32'd64, 32'd32,
		32'd16, 32'd8, 32'd4, 32'd2, 32'd1
	};

	// shift used by hyperbolic stage j: 1,2,3,4,4,5,..,13,13,14,..
	function automatic int hyp_shift(input int j);
		int i;
		i = j + 1;
		if (j >= 4) i = i - 1;
		if (j >= 14) i = i - 1;
		return i;
	endfunction

	typedef struct packed {
		logic             valid;
		cs_word_t         cc;
		cs_word_t         cs;
		cs_word_t         ca;
		cs_word_t         hc;
		cs_word_t         hs;
		cs_word_t         ha;
		logic [1:0]       quad;
		logic signed [3:0] k;
		logic             clamp;
	} cs_lane_t;

endpackage

`default_nettype wire

>>> rtl/core/cs_reduce.sv
// ---------------------------------------------------------------------------
// cs_reduce: argument reduction
// x to quadrant and remainder mod pi/2, clamped y to power of two and remainder
// ---------------------------------------------------------------------------
`default_nettype none

module cs_reduce
	import cs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_valid,
	input  wire cs_data_t real_in,
	input  wire cs_data_t imag_in,
	output cs_lane_t      lane
);

	logic                v_s1, v_s2;
	cs_data_t            x_s1, x_s2;
	cs_data_t            y_s1, y_s2;
	logic                clamp_s1, clamp_s2;
	logic signed [64:0]  px_s1;
	logic signed [63:0]  py_s1;
	logic signed [3:0]   n_s2, k_s2;
	cs_lane_t            lane_s3;

	cs_data_t            y_cl;
	logic                y_hi, y_lo;
	logic signed [64:0]  px_rnd;
	logic signed [63:0]  py_rnd;
	logic signed [65:0]  x_ext, y_ext, n_off, k_off, r_full, t_full;

	always_comb begin
		y_hi = imag_in > $signed(Y_LIMIT);
		y_lo = imag_in < -$signed(Y_LIMIT);
		y_cl = y_hi ? $signed(Y_LIMIT) : (y_lo ? -$signed(Y_LIMIT) : imag_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			x_s1     <= real_in;
			y_s1     <= y_cl;
			clamp_s1 <= y_hi | y_lo;
			px_s1    <= $signed(real_in) * $signed({1'b0, TWO_OVER_PI});
			py_s1    <= $signed(y_cl) * $signed({1'b0, LOG2E_Q30});
		end
	end

	// nearest multiple of pi/2 and of ln2
	always_comb begin
		px_rnd = px_s1 + (65'sd1 <<< 59);
		py_rnd = py_s1 + (64'sd1 <<< 57);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2     <= v_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			clamp_s2 <= clamp_s1;
			n_s2     <= px_rnd[63:60];
			k_s2     <= py_rnd[61:58];
		end
	end

	always_comb begin
		x_ext  = $signed({{2{x_s2[31]}}, x_s2, 32'b0});
		y_ext  = $signed({{2{y_s2[31]}}, y_s2, 32'b0});
		n_off  = $signed(n_s2) * $signed({2'b0, PI_HALF_Q60});
		k_off  = $signed(k_s2) * $signed({2'b0, LN2_Q60});
		r_full = x_ext - n_off;
		t_full = y_ext - k_off;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s3.valid <= 1'b0;
		end else if (en) begin
			lane_s3.valid <= v_s2;
			lane_s3.cc    <= W'(CIRC_GAIN);
			lane_s3.cs    <= '0;
			lane_s3.ca    <= r_full[W+29:30];
			lane_s3.hc    <= W'(HYP_GAIN);
			lane_s3.hs    <= '0;
			lane_s3.ha    <= t_full[W+29:30];
			lane_s3.quad  <= n_s2[1:0];
			lane_s3.k     <= k_s2;
			lane_s3.clamp <= clamp_s2;
		end
	end

	assign lane = lane_s3;

endmodule

`default_nettype wire

>>> rtl/core/cs_cordic.sv
// ---------------------------------------------------------------------------
// cs_cordic: unrolled rotation pipeline
// circular and hyperbolic rotations run side by side, one stage per register
// ---------------------------------------------------------------------------
`default_nettype none

module cs_cordic
	import cs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire cs_lane_t lane_in,
	output cs_lane_t      lane_out
);

	cs_lane_t lane_s [PIPE_N];

	for (genvar j = 0; j < PIPE_N; j++) begin : g_stage
		cs_lane_t cur, nxt;

		if (j == 0) begin : g_first
			assign cur = lane_in;
		end else begin : g_mid
			assign cur = lane_s[j-1];
		end

		always_comb begin
			nxt = cur;
			if (j < STAGES) begin
				if (!cur.ca[W-1]) begin
					nxt.cc = cur.cc - (cur.cs >>> j);
					nxt.cs = cur.cs + (cur.cc >>> j);
					nxt.ca = cur.ca - $signed({2'b0, ATAN_TAB[j]});
				end else begin
					nxt.cc = cur.cc + (cur.cs >>> j);
					nxt.cs = cur.cs - (cur.cc >>> j);
					nxt.ca = cur.ca + $signed({2'b0, ATAN_TAB[j]});
				end
			end
			if (j < HYP_N) begin
				if (!cur.ha[W-1]) begin
					nxt.hc = cur.hc + (cur.hs >>> hyp_shift(j));
					nxt.hs = cur.hs + (cur.hc >>> hyp_shift(j));
					nxt.ha = cur.ha - $signed({2'b0, ATANH_TAB[hyp_shift(j)-1]});
				end else begin
					nxt.hc = cur.hc - (cur.hs >>> hyp_shift(j));
					nxt.hs = cur.hs - (cur.hc >>> hyp_shift(j));
					nxt.ha = cur.ha + $signed({2'b0, ATANH_TAB[hyp_shift(j)-1]});
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lane_s[j].valid <= 1'b0;
			end else if (en) begin
				lane_s[j] <= nxt;
			end
		end
	end

	assign lane_out = lane_s[PIPE_N-1];

endmodule

`default_nettype wire

>>> rtl/core/cs_post.sv
// ---------------------------------------------------------------------------
// cs_post: recombination, saturation and output products
// scales hyperbolic results by 2^k, selects quadrant, multiplies and rounds
// ---------------------------------------------------------------------------
`default_nettype none

module cs_post
	import cs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire cs_lane_t lane,
	output logic          out_valid,
	output cs_data_t      real_out,
	output cs_data_t      imag_out,
	output logic          clamped
);

	logic               v_s1, v_s2, v_s3;
	cs_data_t           sx_s1, cx_s1, ch_s1, sh_s1;
	logic signed [63:0] pre_s2, pim_s2;
	logic               clamp_s1, clamp_s2;
	cs_data_t           re_s3, im_s3;
	logic               clamp_s3;

	logic signed [W:0]    e, f;
	logic signed [41:0]   a, b;
	logic signed [42:0]   asum, adif;
	logic [2:0]           kabs;
	logic signed [3:0]    kneg;
	cs_word_t             sx, cx;
	logic signed [64:0]   re_rnd, im_rnd;
	logic signed [34:0]   re_sh, im_sh;

	function automatic cs_data_t sat(input logic signed [34:0] v);
		if (v > 35'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -35'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	always_comb begin
		e    = lane.hc + lane.hs;
		f    = lane.hc - lane.hs;
		kneg = -lane.k;
		kabs = lane.k[3] ? kneg[2:0] : lane.k[2:0];
		if (!lane.k[3]) begin
			a = 42'(e) <<< kabs;
			b = 42'(f) >>> kabs;
		end else begin
			a = 42'(e) >>> kabs;
			b = 42'(f) <<< kabs;
		end
		asum = 43'(a) + 43'(b);
		adif = 43'(a) - 43'(b);
		case (lane.quad)
			2'd0: begin sx = lane.cs;  cx = lane.cc;  end
			2'd1: begin sx = lane.cc;  cx = -lane.cs; end
			2'd2: begin sx = -lane.cs; cx = -lane.cc; end
			2'd3: begin sx = -lane.cc; cx = lane.cs;  end
			default: begin sx = lane.cs; cx = lane.cc; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1     <= lane.valid;
			sx_s1    <= sx[31:0];
			cx_s1    <= cx[31:0];
			ch_s1    <= asum[36:5];
			sh_s1    <= adif[36:5];
			clamp_s1 <= lane.clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2     <= v_s1;
			pre_s2   <= sx_s1 * ch_s1;
			pim_s2   <= cx_s1 * sh_s1;
			clamp_s2 <= clamp_s1;
		end
	end

	// round half up, then saturate
	always_comb begin
		re_rnd = 65'(pre_s2) + (65'sd1 <<< 29);
		im_rnd = 65'(pim_s2) + (65'sd1 <<< 29);
		re_sh  = re_rnd[64:30];
		im_sh  = im_rnd[64:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3     <= v_s2;
			re_s3    <= sat(re_sh);
			im_s3    <= sat(im_sh);
			clamp_s3 <= clamp_s2;
		end
	end

	assign out_valid = v_s3;
	assign real_out  = re_s3;
	assign imag_out  = im_s3;
	assign clamped   = clamp_s3;

endmodule

`default_nettype wire

>>> rtl/core/complex_sine.sv
// ---------------------------------------------------------------------------
// complex_sine: pipelined complex sine, sin(x+iy)
// real part sin(x)cosh(y), imaginary part cos(x)sinh(y), fixed point
// ---------------------------------------------------------------------------
// usage
//   input stream s_axis: one complex value per transfer, x in Q3.28 radians
//   and y in Q3.28; y is clamped to [-4,4] and the clamp is reported
//   output stream m_axis: one result per transfer, both parts in Q5.26,
//   rounded half up and saturated; tuser[0] flags a clamped y
//   throughput: one transfer per cycle on both sides while the output is not stalled
//   stages: 3 reduction stages, one unrolled stage per rotation (STAGES + 2
//   for STAGES >= 13) and 3 output stages
//   stall: the whole pipeline holds while a result waits on the output
//   register; s_axis_tready drops only then, and no transfer is lost
//   reset: arst_n clears every valid bit; the pipeline comes up empty and
//   ready, no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none

module complex_sine
	import cs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] real_in, [63:32] imag_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [31:0] real_out, [63:32] imag_out
	output logic [0:0]       m_axis_tuser    // [0] clamped
);

	// pipeline advances unless a finished result is stuck at the output
	logic     pipe_en;
	cs_lane_t red_lane, rot_lane;
	cs_data_t real_out, imag_out;
	logic     clamped;

	assign pipe_en       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = pipe_en;

	cs_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (s_axis_tvalid),
		.real_in  (s_axis_tdata[31:0]),
		.imag_in  (s_axis_tdata[63:32]),
		.lane     (red_lane)
	);

	cs_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.lane_in  (red_lane),
		.lane_out (rot_lane)
	);

	// final stage doubles as the output register
	cs_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.lane      (rot_lane),
		.out_valid (m_axis_tvalid),
		.real_out  (real_out),
		.imag_out  (imag_out),
		.clamped   (clamped)
	);

	assign m_axis_tdata    = {imag_out, real_out};
	assign m_axis_tuser[0] = clamped;

`ifndef SYNTHESIS
	// ready only drops behind a waiting result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	// |sin x cosh y| stays below 2^31 in Q5.26, never hits negative saturation
	a_real_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:0] != 32'h80000000)
		else $error("real part out of range");

	a_imag_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:32] != 32'h80000000)
		else $error("imaginary part out of range");
`endif

endmodule

`default_nettype wire
